// ===== rtl/playfair_digraph_encrypt_macros.svh =====
// ----------------------------------------------------------------------------
// Playfair digraph encryptor assertion macros
// Concurrent assertion shorthands used by the pairing front end.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_MACROS_SVH
`ifndef SYNTHESIS
`define PFD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PFD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFD_ASSERT_NOW(name, clk, rst, ante, cons, msg)
`define PFD_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/pfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph encryptor package
// Shared types and constants for the pairing front end and the cipher stage.
// ----------------------------------------------------------------------------
package pfd_pkg;

   localparam int GRID        = 5;
   localparam int GRID_IDX_W  = 3;
   localparam int LETTER_W    = 5;
   localparam int ROW_W       = GRID * LETTER_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = ROW_W;

   localparam logic [LETTER_W-1:0] PAD_LETTER    = 5'd23;
   localparam logic [LETTER_W-1:0] MERGED_RESET  = 5'd9;
   localparam logic [LETTER_W-1:0] HOST_RESET    = 5'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW4   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MERGED = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST   = 3'd6;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                upper;
      logic                end_of_text;
   } req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first_out;
      logic                first_upper;
      logic [LETTER_W-1:0] second_out;
      logic                second_upper;
      logic                final_pair;
   } rsp_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first_letter;
      logic                first_upper;
      logic [LETTER_W-1:0] second_letter;
      logic                second_upper;
      logic                final_pair;
   } job_type;

   typedef struct packed {
      logic [GRID-1:0][GRID-1:0][LETTER_W-1:0] grid_rows;
      logic [LETTER_W-1:0]                     merged_letter;
      logic [LETTER_W-1:0]                     host_letter;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_head_type;

endpackage

// ===== rtl/pfd_pair.sv =====
`timescale 1ns / 1ps
`include "playfair_digraph_encrypt_macros.svh"
// ----------------------------------------------------------------------------
// Playfair digraph pairing front end
// Holds the pending first letter, forms digraphs and queues up to three of
// them for the cipher stage.
// ----------------------------------------------------------------------------
module pfd_pair import pfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req,
   input  cfg_type      cfg,
   input  logic         job_pop,
   output job_head_type job_head
);

   localparam int JOB_DEPTH = 3;
   localparam int COUNT_W   = 2;

   logic                 pend_valid_ff, pend_valid_in;
   logic [LETTER_W-1:0]  pend_letter_ff, pend_letter_in;
   logic                 pend_upper_ff, pend_upper_in;
   job_type              job_ff [JOB_DEPTH];
   job_type              job_in [JOB_DEPTH];
   logic [COUNT_W-1:0]   job_count_ff, job_count_in;
   logic [COUNT_W-1:0]   base_count;
   logic [COUNT_W-1:0]   push_n;
   job_type              job_a, job_b;
   logic                 accept;
   logic [LETTER_W-1:0]  pend_canon, req_canon;

   assign accept    = req_valid && req_ready;
   assign req_ready = !job_count_ff[1];

   assign pend_canon = (pend_letter_ff == cfg.merged_letter) ? cfg.host_letter : pend_letter_ff;
   assign req_canon  = (req.letter == cfg.merged_letter) ? cfg.host_letter : req.letter;

   always_comb begin
      job_a          = '0;
      job_b          = '0;
      push_n         = '0;
      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      pend_upper_in  = pend_upper_ff;
      if (accept) begin
         if (!pend_valid_ff) begin
            if (req.end_of_text) begin
               job_a.first_letter  = req.letter;
               job_a.first_upper   = req.upper;
               job_a.second_letter = PAD_LETTER;
               job_a.final_pair    = 1'b1;
               push_n              = 2'd1;
            end else begin
               pend_valid_in  = 1'b1;
               pend_letter_in = req.letter;
               pend_upper_in  = req.upper;
            end
         end else if (pend_canon == req_canon) begin
            job_a.first_letter  = pend_letter_ff;
            job_a.first_upper   = pend_upper_ff;
            job_a.second_letter = PAD_LETTER;
            push_n              = 2'd1;
            if (req.end_of_text) begin
               job_b.first_letter  = req.letter;
               job_b.first_upper   = req.upper;
               job_b.second_letter = PAD_LETTER;
               job_b.final_pair    = 1'b1;
               push_n              = 2'd2;
               pend_valid_in       = 1'b0;
            end else begin
               pend_letter_in = req.letter;
               pend_upper_in  = req.upper;
            end
         end else begin
            job_a.first_letter  = pend_letter_ff;
            job_a.first_upper   = pend_upper_ff;
            job_a.second_letter = req.letter;
            job_a.second_upper  = req.upper;
            job_a.final_pair    = req.end_of_text;
            push_n              = 2'd1;
            pend_valid_in       = 1'b0;
         end
      end
   end

   always_comb begin
      base_count = job_count_ff - {1'b0, job_pop};
      for (int i = 0; i < JOB_DEPTH; i++) begin
         job_in[i] = job_ff[i];
      end
      if (job_pop) begin
         for (int i = 0; i < JOB_DEPTH - 1; i++) begin
            job_in[i] = job_ff[i+1];
         end
      end
      for (int i = 0; i < JOB_DEPTH; i++) begin
         if (push_n != 2'd0 && base_count == COUNT_W'(i)) begin
            job_in[i] = job_a;
         end
         if (push_n == 2'd2 && (base_count + 2'd1) == COUNT_W'(i)) begin
            job_in[i] = job_b;
         end
      end
      job_count_in = base_count + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         job_count_ff  <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         job_count_ff  <= job_count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_letter_ff <= pend_letter_in;
      pend_upper_ff  <= pend_upper_in;
      for (int i = 0; i < JOB_DEPTH; i++) begin
         job_ff[i] <= job_in[i];
      end
   end

   assign job_head.valid = (job_count_ff != '0);
   assign job_head.job   = job_ff[0];

   `PFD_ASSERT_NEXT(a_eot_clears_pending, clock, reset, accept && req.end_of_text, !pend_valid_ff, "pending letter survives end of text")
   `PFD_ASSERT_NEXT(a_first_letter_held, clock, reset, accept && !pend_valid_ff && !req.end_of_text, pend_valid_ff, "first letter of a digraph was not held")
   `PFD_ASSERT_NOW(a_pop_needs_job, clock, reset, job_pop, job_count_ff != '0, "digraph taken from an empty queue")

endmodule

// ===== rtl/pfd_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher stage
// Looks both letters up in the 5x5 grid, applies the row, column or
// rectangle rule and registers the result.
// ----------------------------------------------------------------------------
module pfd_cipher import pfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  job_head_type job_head,
   output logic         job_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp
);

   typedef struct packed {
      logic [GRID_IDX_W-1:0] row;
      logic [GRID_IDX_W-1:0] col;
   } pos_type;

   function automatic pos_type locate(input logic [LETTER_W-1:0] ltr, input cfg_type c);
      pos_type             pos;
      logic [LETTER_W-1:0] code;
      pos  = '0;
      code = '0;
      for (int r = GRID - 1; r >= 0; r--) begin
         for (int k = GRID - 1; k >= 0; k--) begin
            code = c.grid_rows[r][k];
            if (code == ltr || (ltr == c.merged_letter && code == c.host_letter)) begin
               pos.row = GRID_IDX_W'(r);
               pos.col = GRID_IDX_W'(k);
            end
         end
      end
      return pos;
   endfunction

   function automatic logic [GRID_IDX_W-1:0] step_wrap(input logic [GRID_IDX_W-1:0] x);
      return (x == GRID_IDX_W'(GRID - 1)) ? '0 : x + 1'b1;
   endfunction

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   pos_type              loc1, loc2, dst1, dst2;
   logic                 merged_seen;
   logic [LETTER_W-1:0]  v1, v2;

   assign job_pop = job_head.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      loc1 = locate(job_head.job.first_letter, cfg);
      loc2 = locate(job_head.job.second_letter, cfg);
      dst1 = loc1;
      dst2 = loc2;
      if (loc1.row == loc2.row) begin
         dst1.col = step_wrap(loc1.col);
         dst2.col = step_wrap(loc2.col);
      end else if (loc1.col == loc2.col) begin
         dst1.row = step_wrap(loc1.row);
         dst2.row = step_wrap(loc2.row);
      end else begin
         dst1.col = loc2.col;
         dst2.col = loc1.col;
      end
      v1 = cfg.grid_rows[dst1.row][dst1.col];
      v2 = cfg.grid_rows[dst2.row][dst2.col];
      merged_seen = (job_head.job.first_letter == cfg.merged_letter)
                 || (job_head.job.second_letter == cfg.merged_letter);
      if (merged_seen && v1 == cfg.host_letter) begin
         v1 = cfg.merged_letter;
      end
      if (merged_seen && v2 == cfg.host_letter) begin
         v2 = cfg.merged_letter;
      end
      rsp_in.first_out    = v1;
      rsp_in.first_upper  = job_head.job.first_upper;
      rsp_in.second_out   = v2;
      rsp_in.second_upper = job_head.job.second_upper;
      rsp_in.final_pair   = job_head.job.final_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (job_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/playfair_digraph_encrypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph encryptor
// Pairs a letter stream into digraphs and encrypts each against a 5x5 grid
// held in configuration registers.
//
//   Channel   Ports               Direction  Carries
//   request   req_valid/ready     in         one letter with case and end mark
//   response  rsp_valid/ready     out        one encrypted digraph
//   csr       csr_valid/ready     in         register index and write data
//
// One request is taken per cycle while req_ready is high; a doubled letter
// that also ends the text yields two responses.
// A digraph is registered in the pairing queue, then in the response register.
// The pairing queue holds three digraphs and takes a request while it holds
// at most one, so a stalled response port stops requests once two digraphs
// wait in the queue behind the held response.
// Reset is synchronous; configuration is always ready.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt import pfd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg_ff;
   job_head_type job_head;
   logic         job_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_rows     <= '0;
         cfg_ff.merged_letter <= MERGED_RESET;
         cfg_ff.host_letter   <= HOST_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW0:   cfg_ff.grid_rows[0]  <= csr_wdata;
            CSR_ROW1:   cfg_ff.grid_rows[1]  <= csr_wdata;
            CSR_ROW2:   cfg_ff.grid_rows[2]  <= csr_wdata;
            CSR_ROW3:   cfg_ff.grid_rows[3]  <= csr_wdata;
            CSR_ROW4:   cfg_ff.grid_rows[4]  <= csr_wdata;
            CSR_MERGED: cfg_ff.merged_letter <= csr_wdata[LETTER_W-1:0];
            CSR_HOST:   cfg_ff.host_letter   <= csr_wdata[LETTER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pfd_pair u_pair (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cfg       (cfg_ff),
      .job_pop   (job_pop),
      .job_head  (job_head)
   );

   pfd_cipher u_cipher (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule
